// ----- rtl/gpp_pkg.sv -----
// Shared types and constants of the greedy pool partitioner.
package gpp_pkg;

  localparam int FIELD_W  = 6;   // row, col, pool and item fields
  localparam int SCORE_W  = 16;  // score and min_score fields
  localparam int CFG_W    = 7;   // item_count and pool_size registers
  localparam int CIDX_W   = 2;   // configuration register index
  localparam int CDATA_W  = 16;  // configuration write data
  localparam int SADDR_W  = 7;   // widest slot address (2 * 64 slots)
  localparam int CNT_W    = 8;   // loop counters, hold up to 2 * 64

  localparam int MAX_ITEMS_DEF  = 64;
  localparam int SCORE_BITS_DEF = 16;

  localparam logic [CFG_W-1:0] ITEM_COUNT_RST = 7'd64;
  localparam logic [CFG_W-1:0] POOL_SIZE_RST  = 7'd8;

  typedef enum logic [CIDX_W-1:0] {
    REG_ITEM_COUNT = 2'd0,
    REG_POOL_SIZE  = 2'd1,
    REG_MIN_SCORE  = 2'd2
  } gpp_reg_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_CLR, OP_FILL, OP_RDA, OP_RDB, OP_RDM,
    OP_WRA, OP_WRB, OP_KILL, OP_RDK, OP_EMITK, OP_EMITS
  } gpp_op_t;

  typedef struct packed {
    gpp_op_t              op;
    logic [SADDR_W-1:0]   a;
    logic [SADDR_W-1:0]   b;
    logic [FIELD_W-1:0]   pool;
    logic                 last;
  } gpp_cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] n;
    logic [CFG_W-1:0] ps;
    logic [CFG_W-1:0] kc;
    logic             conf;
    logic             used_a;
    logic             out_free;
  } gpp_sts_t;

endpackage

// ----- rtl/gpp_in_if.sv -----
// Input channel: one score matrix entry per word.
interface gpp_in_if;
  logic                               valid;
  logic                               ready;
  logic [gpp_pkg::FIELD_W-1:0]        row;
  logic [gpp_pkg::FIELD_W-1:0]        col;
  logic signed [gpp_pkg::SCORE_W-1:0] score;
  logic                               last;
  modport source (output valid, row, col, score, last, input ready);
  modport sink   (input valid, row, col, score, last, output ready);
endinterface

// ----- rtl/gpp_out_if.sv -----
// Result channel: one killed item or pool member per word.
interface gpp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        record_kind;
  logic [gpp_pkg::FIELD_W-1:0] pool_number;
  logic [gpp_pkg::FIELD_W-1:0] item_index;
  logic                        last_result;
  modport source (output valid, record_kind, pool_number, item_index, last_result,
                  input ready);
  modport sink   (input valid, record_kind, pool_number, item_index, last_result,
                  output ready);
endinterface

// ----- rtl/gpp_cfg_if.sv -----
// Configuration write channel.
interface gpp_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [gpp_pkg::CIDX_W-1:0]  index;
  logic [gpp_pkg::CDATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/gpp_dp.sv -----
// Datapath: configuration, score memory, pool slots, kill list and output register.
module gpp_dp #(
  parameter int MAX_ITEMS  = gpp_pkg::MAX_ITEMS_DEF,
  parameter int SCORE_BITS = gpp_pkg::SCORE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gpp_pkg::gpp_cmd_t cmd,
  output gpp_pkg::gpp_sts_t sts,
  gpp_in_if.sink            in_ch,
  gpp_cfg_if.sink           cfg_ch,
  gpp_out_if.source         out_ch
);

  localparam int ROW_W     = $clog2(MAX_ITEMS);
  localparam int MAT_DEPTH = MAX_ITEMS * MAX_ITEMS;
  localparam int MADDR_W   = $clog2(MAT_DEPTH);
  localparam int SLOTS     = 2 * MAX_ITEMS;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam longint SC_HI = (longint'(1) <<< (SCORE_BITS - 1)) - 1;
  localparam longint SC_LO = -SC_HI - 1;
  localparam logic [gpp_pkg::CFG_W-1:0] MAX_CFG = gpp_pkg::CFG_W'(MAX_ITEMS);

  logic [gpp_pkg::CFG_W-1:0]         item_count_r, pool_size_r, kc_r;
  logic signed [gpp_pkg::SCORE_W-1:0] min_score_r;

  logic signed [SCORE_BITS-1:0] mat_mem [MAT_DEPTH];
  logic signed [SCORE_BITS-1:0] mdata_r;
  logic [ROW_W-1:0]             slot_item [SLOTS];
  logic [SLOTS-1:0]             used_r;
  logic [2*ROW_W-1:0]           kill_mem [MAX_ITEMS];
  logic [2*ROW_W-1:0]           kill_rd_r;
  logic [ROW_W-1:0]             item_a_r, item_b_r;
  logic                         used_a_r, used_b_r;

  logic                         out_valid_r, kind_r, last_r;
  logic [gpp_pkg::FIELD_W-1:0]  pool_r, item_r;

  logic                         out_free, in_range;
  logic [MADDR_W-1:0]           wr_addr, rd_addr;
  logic [SLOT_W-1:0]            sa, sb, srd;
  longint                       sc_in, sc_sat;

  function automatic logic [gpp_pkg::CFG_W-1:0] clamp_cfg(
    input logic [gpp_pkg::CFG_W-1:0] v);
    logic [gpp_pkg::CFG_W-1:0] res;
    res = v;
    if (v == '0) res = gpp_pkg::CFG_W'(1);
    else if (v > MAX_CFG) res = MAX_CFG;
    return res;
  endfunction

  assign sa  = cmd.a[SLOT_W-1:0];
  assign sb  = cmd.b[SLOT_W-1:0];
  assign srd = (cmd.op == gpp_pkg::OP_RDB) ? sb : sa;

  assign in_range = (int'(in_ch.row) < MAX_ITEMS) && (int'(in_ch.col) < MAX_ITEMS);
  assign wr_addr  = MADDR_W'(int'(in_ch.row) * MAX_ITEMS + int'(in_ch.col));
  assign rd_addr  = MADDR_W'(int'(item_a_r) * MAX_ITEMS + int'(item_b_r));

  always_comb begin
    sc_in  = longint'(in_ch.score);
    sc_sat = sc_in;
    if (sc_in > SC_HI) sc_sat = SC_HI;
    else if (sc_in < SC_LO) sc_sat = SC_LO;
  end

  // Configuration registers.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_count_r <= gpp_pkg::ITEM_COUNT_RST;
      pool_size_r  <= gpp_pkg::POOL_SIZE_RST;
      min_score_r  <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        gpp_pkg::REG_ITEM_COUNT: item_count_r <= cfg_ch.data[gpp_pkg::CFG_W-1:0];
        gpp_pkg::REG_POOL_SIZE:  pool_size_r  <= cfg_ch.data[gpp_pkg::CFG_W-1:0];
        gpp_pkg::REG_MIN_SCORE:  min_score_r  <= signed'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  // Score memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.op == gpp_pkg::OP_LOAD && in_range) begin
      mat_mem[wr_addr] <= SCORE_BITS'(sc_sat);
    end
    if (cmd.op == gpp_pkg::OP_RDM) begin
      mdata_r <= mat_mem[rd_addr];
    end
  end

  // Slot items and kill list memories.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      gpp_pkg::OP_FILL: slot_item[sa] <= cmd.a[ROW_W-1:0];
      gpp_pkg::OP_WRA:  slot_item[sa] <= item_b_r;
      gpp_pkg::OP_WRB:  slot_item[sb] <= item_a_r;
      gpp_pkg::OP_KILL: begin
        if (kc_r < MAX_CFG) kill_mem[kc_r[ROW_W-1:0]] <= {cmd.pool[ROW_W-1:0], item_b_r};
      end
      default: ;
    endcase
    if (cmd.op == gpp_pkg::OP_RDA) begin
      item_a_r <= slot_item[srd];
      used_a_r <= used_r[srd];
    end
    if (cmd.op == gpp_pkg::OP_RDB) begin
      item_b_r <= slot_item[srd];
      used_b_r <= used_r[srd];
    end
    if (cmd.op == gpp_pkg::OP_RDK) begin
      kill_rd_r <= kill_mem[cmd.a[ROW_W-1:0]];
    end
  end

  // Slot valid bits and kill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      kc_r   <= '0;
    end else begin
      unique case (cmd.op)
        gpp_pkg::OP_CLR: begin
          used_r <= '0;
          kc_r   <= '0;
        end
        gpp_pkg::OP_FILL: used_r[sa] <= 1'b1;
        gpp_pkg::OP_WRA:  used_r[sa] <= used_b_r;
        gpp_pkg::OP_WRB:  used_r[sb] <= used_a_r;
        gpp_pkg::OP_KILL: begin
          used_r[sb] <= 1'b0;
          if (kc_r < MAX_CFG) kc_r <= kc_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Output register; it frees up in the same cycle its word is taken.
  assign out_free = !out_valid_r || out_ch.ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == gpp_pkg::OP_EMITK || cmd.op == gpp_pkg::OP_EMITS) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.op == gpp_pkg::OP_EMITK) begin
      kind_r <= 1'b1;
      pool_r <= gpp_pkg::FIELD_W'(kill_rd_r[2*ROW_W-1:ROW_W]);
      item_r <= gpp_pkg::FIELD_W'(kill_rd_r[ROW_W-1:0]);
      last_r <= cmd.last;
    end else if (cmd.op == gpp_pkg::OP_EMITS) begin
      kind_r <= 1'b0;
      pool_r <= cmd.pool;
      item_r <= gpp_pkg::FIELD_W'(item_a_r);
      last_r <= cmd.last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.record_kind = kind_r;
  assign out_ch.pool_number = pool_r;
  assign out_ch.item_index  = item_r;
  assign out_ch.last_result = last_r;

  assign sts.n        = clamp_cfg(item_count_r);
  assign sts.ps       = clamp_cfg(pool_size_r);
  assign sts.kc       = kc_r;
  assign sts.used_a   = used_a_r;
  assign sts.out_free = out_free;
  assign sts.conf     = used_a_r && used_b_r &&
                        (longint'(mdata_r) <= longint'(min_score_r));

  a_kc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kc_r <= MAX_CFG) else $error("kill count beyond item limit");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == gpp_pkg::OP_EMITK || cmd.op == gpp_pkg::OP_EMITS) |-> out_free)
    else $error("output register overwritten");
  a_clr_kc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == gpp_pkg::OP_CLR |=> kc_r == '0) else $error("kill count not cleared");

endmodule

// ----- rtl/gpp_ctrl.sv -----
// Controller: sequences loading, placement, pool screening and record output.
module gpp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  gpp_pkg::gpp_sts_t sts,
  output gpp_pkg::gpp_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_FILL, S_PLOOP, S_ILOOP, S_JLOOP,
    S_CA, S_CB, S_CM, S_CE,
    S_QLOOP, S_FI, S_FJ, S_FDEC, S_K2, S_K3,
    S_SWA, S_SWB, S_SW1, S_SW2, S_KRB, S_KILL,
    S_OKRD, S_OKEM, S_OPL, S_OM, S_OEM
  } state_t;

  typedef enum logic [1:0] {R_PAIR, R_FI, R_FJ, R_FK} ret_t;

  localparam int W = gpp_pkg::CNT_W;

  state_t state_r, state_nxt;
  ret_t   ret_r, ret_nxt;
  logic [W-1:0] pbase_r, pbase_nxt, p_r, p_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [W-1:0] qbase_r, qbase_nxt, q_r, q_nxt, k_r, k_nxt, k2_r, k2_nxt;
  logic [W-1:0] ca_r, ca_nxt, cb_r, cb_nxt, emit_r, emit_nxt;
  logic         iok_r, iok_nxt, jok_r, jok_nxt;
  logic [W-1:0] n, ps, kc, si, sj, swa, swb, om_slot;
  logic         is_last;

  assign n       = W'(sts.n);
  assign ps      = W'(sts.ps);
  assign kc      = W'(sts.kc);
  assign si      = pbase_r + i_r;
  assign sj      = pbase_r + j_r;
  assign swa     = iok_r ? si : sj;
  assign swb     = qbase_r + k2_r;
  assign om_slot = pbase_r + k_r;
  assign is_last = (emit_r == n - 1'b1);

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    pbase_nxt = pbase_r;
    p_nxt     = p_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    qbase_nxt = qbase_r;
    q_nxt     = q_r;
    k_nxt     = k_r;
    k2_nxt    = k2_r;
    ca_nxt    = ca_r;
    cb_nxt    = cb_r;
    emit_nxt  = emit_r;
    iok_nxt   = iok_r;
    jok_nxt   = jok_r;
    cmd       = '0;
    cmd.op    = gpp_pkg::OP_NOP;
    cmd.pool  = p_r[gpp_pkg::FIELD_W-1:0];
    cmd.last  = is_last;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = gpp_pkg::OP_LOAD;
          if (in_last) state_nxt = S_CLR;
        end
      end
      S_CLR: begin
        cmd.op    = gpp_pkg::OP_CLR;
        k_nxt     = '0;
        emit_nxt  = '0;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        if (k_r < n) begin
          cmd.op = gpp_pkg::OP_FILL;
          cmd.a  = k_r[gpp_pkg::SADDR_W-1:0];
          k_nxt  = k_r + 1'b1;
        end else begin
          pbase_nxt = '0;
          p_nxt     = '0;
          state_nxt = S_PLOOP;
        end
      end
      S_PLOOP: begin
        if (pbase_r < n) begin
          i_nxt     = '0;
          state_nxt = S_ILOOP;
        end else begin
          k_nxt     = '0;
          state_nxt = S_OKRD;
        end
      end
      S_ILOOP: begin
        if (i_r < ps) begin
          j_nxt     = i_r + 1'b1;
          state_nxt = S_JLOOP;
        end else begin
          pbase_nxt = pbase_r + ps;
          p_nxt     = p_r + 1'b1;
          state_nxt = S_PLOOP;
        end
      end
      S_JLOOP: begin
        if (j_r < ps) begin
          ca_nxt    = si;
          cb_nxt    = sj;
          ret_nxt   = R_PAIR;
          state_nxt = S_CA;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_ILOOP;
        end
      end
      // Conflict check of slots ca and cb: read both, read their score, compare.
      S_CA: begin
        cmd.op    = gpp_pkg::OP_RDA;
        cmd.a     = ca_r[gpp_pkg::SADDR_W-1:0];
        state_nxt = S_CB;
      end
      S_CB: begin
        cmd.op    = gpp_pkg::OP_RDB;
        cmd.b     = cb_r[gpp_pkg::SADDR_W-1:0];
        state_nxt = S_CM;
      end
      S_CM: begin
        cmd.op    = gpp_pkg::OP_RDM;
        state_nxt = S_CE;
      end
      S_CE: begin
        unique case (ret_r)
          R_PAIR: begin
            if (sts.conf) begin
              qbase_nxt = '0;
              q_nxt     = '0;
              state_nxt = S_QLOOP;
            end else begin
              j_nxt     = j_r + 1'b1;
              state_nxt = S_JLOOP;
            end
          end
          R_FI: begin
            if (sts.conf) begin
              iok_nxt   = 1'b0;
              k_nxt     = '0;
              jok_nxt   = 1'b1;
              state_nxt = S_FJ;
            end else begin
              k_nxt     = k_r + 1'b1;
              state_nxt = S_FI;
            end
          end
          R_FJ: begin
            if (sts.conf) begin
              jok_nxt   = 1'b0;
              state_nxt = S_FDEC;
            end else begin
              k_nxt     = k_r + 1'b1;
              state_nxt = S_FJ;
            end
          end
          R_FK: begin
            if (sts.conf) begin
              k2_nxt    = k2_r + 1'b1;
              state_nxt = S_K2;
            end else begin
              k_nxt     = k_r + 1'b1;
              state_nxt = S_K3;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_QLOOP: begin
        if (qbase_r < n) begin
          if (q_r == p_r) begin
            qbase_nxt = qbase_r + ps;
            q_nxt     = q_r + 1'b1;
          end else begin
            k_nxt     = '0;
            iok_nxt   = 1'b1;
            state_nxt = S_FI;
          end
        end else begin
          state_nxt = S_KRB;
        end
      end
      S_FI: begin
        if (k_r < ps) begin
          ca_nxt    = si;
          cb_nxt    = qbase_r + k_r;
          ret_nxt   = R_FI;
          state_nxt = S_CA;
        end else begin
          k_nxt     = '0;
          jok_nxt   = 1'b1;
          state_nxt = S_FJ;
        end
      end
      S_FJ: begin
        if (k_r < ps) begin
          ca_nxt    = sj;
          cb_nxt    = qbase_r + k_r;
          ret_nxt   = R_FJ;
          state_nxt = S_CA;
        end else begin
          state_nxt = S_FDEC;
        end
      end
      S_FDEC: begin
        if (!iok_r && !jok_r) begin
          qbase_nxt = qbase_r + ps;
          q_nxt     = q_r + 1'b1;
          state_nxt = S_QLOOP;
        end else begin
          k2_nxt    = '0;
          state_nxt = S_K2;
        end
      end
      S_K2: begin
        if (k2_r < ps) begin
          k_nxt     = '0;
          state_nxt = S_K3;
        end else begin
          qbase_nxt = qbase_r + ps;
          q_nxt     = q_r + 1'b1;
          state_nxt = S_QLOOP;
        end
      end
      S_K3: begin
        if (k_r < ps) begin
          ca_nxt    = swb;
          cb_nxt    = pbase_r + k_r;
          ret_nxt   = R_FK;
          state_nxt = S_CA;
        end else begin
          state_nxt = S_SWA;
        end
      end
      S_SWA: begin
        cmd.op    = gpp_pkg::OP_RDA;
        cmd.a     = swa[gpp_pkg::SADDR_W-1:0];
        state_nxt = S_SWB;
      end
      S_SWB: begin
        cmd.op    = gpp_pkg::OP_RDB;
        cmd.b     = swb[gpp_pkg::SADDR_W-1:0];
        state_nxt = S_SW1;
      end
      S_SW1: begin
        cmd.op    = gpp_pkg::OP_WRA;
        cmd.a     = swa[gpp_pkg::SADDR_W-1:0];
        state_nxt = S_SW2;
      end
      S_SW2: begin
        cmd.op    = gpp_pkg::OP_WRB;
        cmd.b     = swb[gpp_pkg::SADDR_W-1:0];
        j_nxt     = j_r + 1'b1;
        state_nxt = S_JLOOP;
      end
      S_KRB: begin
        cmd.op    = gpp_pkg::OP_RDB;
        cmd.b     = sj[gpp_pkg::SADDR_W-1:0];
        state_nxt = S_KILL;
      end
      S_KILL: begin
        cmd.op    = gpp_pkg::OP_KILL;
        cmd.b     = sj[gpp_pkg::SADDR_W-1:0];
        j_nxt     = j_r + 1'b1;
        state_nxt = S_JLOOP;
      end
      S_OKRD: begin
        if (k_r < kc) begin
          cmd.op    = gpp_pkg::OP_RDK;
          cmd.a     = k_r[gpp_pkg::SADDR_W-1:0];
          state_nxt = S_OKEM;
        end else begin
          pbase_nxt = '0;
          p_nxt     = '0;
          state_nxt = S_OPL;
        end
      end
      S_OKEM: begin
        if (sts.out_free) begin
          cmd.op    = gpp_pkg::OP_EMITK;
          emit_nxt  = emit_r + 1'b1;
          k_nxt     = k_r + 1'b1;
          state_nxt = S_OKRD;
        end
      end
      S_OPL: begin
        if (pbase_r < n) begin
          k_nxt     = '0;
          state_nxt = S_OM;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OM: begin
        if (k_r < ps) begin
          cmd.op    = gpp_pkg::OP_RDA;
          cmd.a     = om_slot[gpp_pkg::SADDR_W-1:0];
          state_nxt = S_OEM;
        end else begin
          pbase_nxt = pbase_r + ps;
          p_nxt     = p_r + 1'b1;
          state_nxt = S_OPL;
        end
      end
      S_OEM: begin
        if (!sts.used_a) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_OM;
        end else if (sts.out_free) begin
          cmd.op    = gpp_pkg::OP_EMITS;
          emit_nxt  = emit_r + 1'b1;
          k_nxt     = k_r + 1'b1;
          state_nxt = S_OM;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= R_PAIR;
      emit_r  <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      emit_r  <= emit_nxt;
      k_r     <= k_nxt;
    end
    pbase_r <= pbase_nxt;
    p_r     <= p_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    qbase_r <= qbase_nxt;
    q_r     <= q_nxt;
    k2_r    <= k2_nxt;
    ca_r    <= ca_nxt;
    cb_r    <= cb_nxt;
    iok_r   <= iok_nxt;
    jok_r   <= jok_nxt;
  end

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == gpp_pkg::OP_EMITK || cmd.op == gpp_pkg::OP_EMITS) |-> emit_r < n)
    else $error("more records than items");
  a_check_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CM |-> $past(state_r) == S_CB) else $error("broken check sequence");
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> $past(in_valid && in_last && state_r == S_IDLE))
    else $error("run started without a final entry");

endmodule

// ----- rtl/greedy_pool_partitioner_top.sv -----
// Top level of the greedy pool partitioner.
//
//   channel | dir | word
//   in_ch   | in  | row, col, score, last: one score matrix entry
//   out_ch  | out | record_kind, pool_number, item_index, last_result
//   cfg_ch  | in  | index, data: item_count, pool_size, min_score
//
// A matrix entry is taken while in_ch.ready is high. The entry with last set
// starts a run during which in_ch.ready is low; each pair score check in it
// does two slot reads, one score read from the single score memory read port,
// the compare and a loop step. Output reads and emits each kill record, reads each
// slot, used or empty, emits the used ones; a stalled out_ch holds the run.
// Reset clears the slot valid bits at once, no sweep.
module greedy_pool_partitioner_top #(
  parameter int MAX_ITEMS  = gpp_pkg::MAX_ITEMS_DEF,
  parameter int SCORE_BITS = gpp_pkg::SCORE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  gpp_in_if.sink     in_ch,
  gpp_out_if.source  out_ch,
  gpp_cfg_if.sink    cfg_ch
);

  gpp_pkg::gpp_cmd_t cmd;
  gpp_pkg::gpp_sts_t sts;

  gpp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gpp_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .SCORE_BITS (SCORE_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

endmodule
